>>> sv/pts_pkg.sv
// Shared types and constants for the Pascal token scanner.
// Holds scan states, token kinds, operator codes and character codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package pts_pkg;

   // default widths of the numeric and length fields
   localparam int MANTISSA_BITS_DEF = 32;
   localparam int LENGTH_BITS_DEF   = 16;

   // fixed field widths
   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;
   localparam int OP_W   = 5;
   localparam int FRAC_W = 4;

   // token queue depth (two pushes per item at most)
   localparam int TQ_DEPTH = 4;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_COLON  = 4'd1,
      ST_LT     = 4'd2,
      ST_GT     = 4'd3,
      ST_DOT    = 4'd4,
      ST_SLASH  = 4'd5,
      ST_LINE   = 4'd6,
      ST_LPAREN = 4'd7,
      ST_PCOM   = 4'd8,
      ST_PSTAR  = 4'd9,
      ST_BRACE  = 4'd10,
      ST_STRING = 4'd11,
      ST_INT    = 4'd12,
      ST_INTDOT = 4'd13,
      ST_FRAC   = 4'd14
   } scan_state_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OP   = 3'd0,
      KIND_INT  = 3'd1,
      KIND_REAL = 3'd2,
      KIND_STR  = 3'd3,
      KIND_COM  = 3'd4,
      KIND_ERR  = 3'd5
   } tok_kind_type;

   // operator codes
   localparam logic [OP_W-1:0] OP_ASSIGN   = 5'd0;
   localparam logic [OP_W-1:0] OP_COLON    = 5'd1;
   localparam logic [OP_W-1:0] OP_NE       = 5'd2;
   localparam logic [OP_W-1:0] OP_LE       = 5'd3;
   localparam logic [OP_W-1:0] OP_LT       = 5'd4;
   localparam logic [OP_W-1:0] OP_GE       = 5'd5;
   localparam logic [OP_W-1:0] OP_GT       = 5'd6;
   localparam logic [OP_W-1:0] OP_SEMI     = 5'd7;
   localparam logic [OP_W-1:0] OP_DOT      = 5'd8;
   localparam logic [OP_W-1:0] OP_ELLIPSIS = 5'd9;
   localparam logic [OP_W-1:0] OP_PLUS     = 5'd10;
   localparam logic [OP_W-1:0] OP_MINUS    = 5'd11;
   localparam logic [OP_W-1:0] OP_SLASH    = 5'd12;
   localparam logic [OP_W-1:0] OP_EQ       = 5'd13;
   localparam logic [OP_W-1:0] OP_STAR     = 5'd14;
   localparam logic [OP_W-1:0] OP_LPAREN   = 5'd15;
   localparam logic [OP_W-1:0] OP_RPAREN   = 5'd16;
   localparam logic [OP_W-1:0] OP_LBRACK   = 5'd17;
   localparam logic [OP_W-1:0] OP_RBRACK   = 5'd18;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
   localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

   // token pushes from the scanner into the result queue
   typedef struct packed {
      logic push_a;
      logic push_b;
   } tok_push_type;

endpackage

`default_nettype wire

>>> sv/pts_core.sv
// Scanner core: input register, scan state and the single-pass token logic.
// Produces up to two queue entries per item. Depends on pts_pkg.
`default_nettype none

module pts_core #(
   parameter int MANTISSA_BITS = pts_pkg::MANTISSA_BITS_DEF,
   parameter int LENGTH_BITS   = pts_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [pts_pkg::CHAR_W-1:0]   req_char,
   input  wire logic                         req_eoi,
   input  wire logic                         room,
   output pts_pkg::tok_push_type             push,
   output logic [1+pts_pkg::KIND_W+pts_pkg::OP_W+MANTISSA_BITS+pts_pkg::FRAC_W
                 +LENGTH_BITS-1:0]           ent_a,
   output logic [1+pts_pkg::KIND_W+pts_pkg::OP_W+MANTISSA_BITS+pts_pkg::FRAC_W
                 +LENGTH_BITS-1:0]           ent_b
);
   import pts_pkg::*;

   localparam int M     = MANTISSA_BITS;
   localparam int L     = LENGTH_BITS;
   localparam int TOK_W = KIND_W + L + FRAC_W + M + OP_W;

   // input register
   logic              in_vld_ff, in_vld_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_eoi_ff;
   logic              fire;

   // scan state
   scan_state_type    st_ff, st_in;
   logic [M-1:0]      acc_ff, acc_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [L-1:0]      tcnt_ff, tcnt_in;

   // token {kind, len, frac, mant, op}
   function automatic logic [TOK_W-1:0] tok_make(tok_kind_type k, logic [OP_W-1:0] op,
                                                 logic [M-1:0] mant,
                                                 logic [FRAC_W-1:0] fr,
                                                 logic [L-1:0] len);
      return {k, len, fr, mant, op};
   endfunction

   function automatic logic [TOK_W-1:0] op_tok(logic [OP_W-1:0] op);
      return tok_make(KIND_OP, op, '0, '0, '0);
   endfunction

   assign fire       = in_vld_ff && room;
   assign req_tready = !in_vld_ff || fire;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_char;
         in_eoi_ff  <= req_eoi;
      end
   end

   // digit accumulate with saturation: acc*10+d as two shifted adds
   logic              is_dig;
   logic [3:0]        dig_val;
   logic [M+3:0]      acc_x10;
   logic [M-1:0]      acc_add;
   logic [L-1:0]      tcnt_inc;
   logic [FRAC_W-1:0] frac_inc;

   assign is_dig   = (in_char_ff >= CH_0) && (in_char_ff <= CH_9);
   assign dig_val  = in_char_ff[3:0];   // low nibble of an ASCII digit is its value
   assign acc_x10  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + (M+4)'(dig_val);
   assign acc_add  = (acc_x10[M+3:M] != 4'd0) ? {M{1'b1}} : acc_x10[M-1:0];
   assign tcnt_inc = (&tcnt_ff) ? tcnt_ff : L'(tcnt_ff + 1'b1);
   assign frac_inc = (&frac_ff) ? frac_ff : FRAC_W'(frac_ff + 1'b1);

   // scan of a character from idle
   logic             idle_emit, idle_tcnt1, idle_digit;
   logic [TOK_W-1:0] idle_tok;
   scan_state_type   idle_st;

   always_comb begin
      idle_emit  = 1'b0;
      idle_tcnt1 = 1'b0;
      idle_digit = 1'b0;
      idle_tok   = '0;
      idle_st    = ST_IDLE;
      case (in_char_ff)
         CH_SPACE, CH_NL: ;
         CH_COLON:  idle_st = ST_COLON;
         CH_LT:     idle_st = ST_LT;
         CH_GT:     idle_st = ST_GT;
         CH_DOT:    idle_st = ST_DOT;
         CH_SLASH:  idle_st = ST_SLASH;
         CH_LPAREN: idle_st = ST_LPAREN;
         CH_LBRACE: begin
            idle_tcnt1 = 1'b1;
            idle_st    = ST_BRACE;
         end
         CH_QUOTE: begin
            idle_tcnt1 = 1'b1;
            idle_st    = ST_STRING;
         end
         CH_SEMI:   begin idle_emit = 1'b1; idle_tok = op_tok(OP_SEMI);     end
         CH_PLUS:   begin idle_emit = 1'b1; idle_tok = op_tok(OP_PLUS);     end
         CH_MINUS:  begin idle_emit = 1'b1; idle_tok = op_tok(OP_MINUS);    end
         CH_EQ:     begin idle_emit = 1'b1; idle_tok = op_tok(OP_EQ);       end
         CH_STAR:   begin idle_emit = 1'b1; idle_tok = op_tok(OP_STAR);     end
         CH_RPAREN: begin idle_emit = 1'b1; idle_tok = op_tok(OP_RPAREN);   end
         CH_LBRACK: begin idle_emit = 1'b1; idle_tok = op_tok(OP_LBRACK);   end
         CH_RBRACK: begin idle_emit = 1'b1; idle_tok = op_tok(OP_RBRACK);   end
         CH_AMP:    begin idle_emit = 1'b1; idle_tok = op_tok(OP_ELLIPSIS); end
         default: begin
            if (is_dig) begin
               idle_digit = 1'b1;
               idle_st    = ST_INT;
            end else begin
               idle_emit = 1'b1;
               idle_tok  = tok_make(KIND_ERR, '0, '0, '0, '0);
            end
         end
      endcase
   end

   // pending token of the current state
   logic             flush_emit;
   logic [TOK_W-1:0] flush_tok;

   always_comb begin
      flush_emit = 1'b1;
      flush_tok  = '0;
      case (st_ff)
         ST_COLON:  flush_tok = op_tok(OP_COLON);
         ST_LT:     flush_tok = op_tok(OP_LT);
         ST_GT:     flush_tok = op_tok(OP_GT);
         ST_DOT:    flush_tok = op_tok(OP_DOT);
         ST_SLASH:  flush_tok = op_tok(OP_SLASH);
         ST_LPAREN: flush_tok = op_tok(OP_LPAREN);
         ST_LINE, ST_PCOM, ST_PSTAR, ST_BRACE:
            flush_tok = tok_make(KIND_COM, '0, '0, '0, tcnt_ff);
         ST_STRING: flush_tok = tok_make(KIND_STR, '0, '0, '0, tcnt_ff);
         ST_INT:    flush_tok = tok_make(KIND_INT, '0, acc_ff, '0, '0);
         ST_INTDOT, ST_FRAC:
            flush_tok = tok_make(KIND_REAL, '0, acc_ff, frac_ff, '0);
         default:   flush_emit = 1'b0;
      endcase
   end

   // next state and tokens for the item in the input register
   logic             emit_a, emit_b, again, use_idle;
   logic [TOK_W-1:0] tok_a, tok_b;

   always_comb begin
      st_in    = st_ff;
      acc_in   = acc_ff;
      frac_in  = frac_ff;
      tcnt_in  = tcnt_ff;
      emit_a   = 1'b0;
      emit_b   = 1'b0;
      tok_a    = '0;
      tok_b    = '0;
      again    = 1'b0;
      use_idle = 1'b0;
      if (in_eoi_ff) begin
         emit_a = flush_emit;
         tok_a  = flush_tok;
         st_in  = ST_IDLE;
      end else begin
         case (st_ff)
            ST_IDLE: use_idle = 1'b1;
            ST_COLON: begin
               if (in_char_ff == CH_EQ) begin
                  emit_a = 1'b1; tok_a = op_tok(OP_ASSIGN); st_in = ST_IDLE;
               end else again = 1'b1;
            end
            ST_LT: begin
               if (in_char_ff == CH_GT) begin
                  emit_a = 1'b1; tok_a = op_tok(OP_NE); st_in = ST_IDLE;
               end else if (in_char_ff == CH_EQ) begin
                  emit_a = 1'b1; tok_a = op_tok(OP_LE); st_in = ST_IDLE;
               end else again = 1'b1;
            end
            ST_GT: begin
               if (in_char_ff == CH_EQ) begin
                  emit_a = 1'b1; tok_a = op_tok(OP_GE); st_in = ST_IDLE;
               end else again = 1'b1;
            end
            ST_DOT: begin
               if (in_char_ff == CH_DOT) begin
                  emit_a = 1'b1; tok_a = op_tok(OP_ELLIPSIS); st_in = ST_IDLE;
               end else again = 1'b1;
            end
            ST_SLASH: begin
               if (in_char_ff == CH_SLASH) begin
                  tcnt_in = L'(2); st_in = ST_LINE;
               end else again = 1'b1;
            end
            ST_LINE: begin
               // newline ends the comment and is not counted
               if (in_char_ff == CH_NL) begin
                  emit_a = 1'b1;
                  tok_a  = tok_make(KIND_COM, '0, '0, '0, tcnt_ff);
                  st_in  = ST_IDLE;
               end else tcnt_in = tcnt_inc;
            end
            ST_LPAREN: begin
               if (in_char_ff == CH_STAR) begin
                  tcnt_in = L'(2); st_in = ST_PCOM;
               end else again = 1'b1;
            end
            ST_PCOM: begin
               tcnt_in = tcnt_inc;
               if (in_char_ff == CH_STAR) st_in = ST_PSTAR;
            end
            ST_PSTAR: begin
               tcnt_in = tcnt_inc;
               if (in_char_ff == CH_RPAREN) begin
                  emit_a = 1'b1;
                  tok_a  = tok_make(KIND_COM, '0, '0, '0, tcnt_inc);
                  st_in  = ST_IDLE;
               end else if (in_char_ff != CH_STAR) st_in = ST_PCOM;
            end
            ST_BRACE: begin
               tcnt_in = tcnt_inc;
               if (in_char_ff == CH_RBRACE) begin
                  emit_a = 1'b1;
                  tok_a  = tok_make(KIND_COM, '0, '0, '0, tcnt_inc);
                  st_in  = ST_IDLE;
               end
            end
            ST_STRING: begin
               tcnt_in = tcnt_inc;
               if (in_char_ff == CH_QUOTE) begin
                  emit_a = 1'b1;
                  tok_a  = tok_make(KIND_STR, '0, '0, '0, tcnt_inc);
                  st_in  = ST_IDLE;
               end
            end
            ST_INT: begin
               if (is_dig) acc_in = acc_add;
               else if (in_char_ff == CH_DOT) st_in = ST_INTDOT;
               else again = 1'b1;
            end
            ST_INTDOT: begin
               // number followed by two points: int then ellipsis
               if (in_char_ff == CH_DOT) begin
                  emit_a = 1'b1;
                  tok_a  = tok_make(KIND_INT, '0, acc_ff, '0, '0);
                  emit_b = 1'b1;
                  tok_b  = op_tok(OP_ELLIPSIS);
                  st_in  = ST_IDLE;
               end else if (is_dig) begin
                  acc_in  = acc_add;
                  frac_in = FRAC_W'(1);
                  st_in   = ST_FRAC;
               end else again = 1'b1;
            end
            ST_FRAC: begin
               if (is_dig) begin
                  acc_in  = acc_add;
                  frac_in = frac_inc;
               end else again = 1'b1;
            end
            default: use_idle = 1'b1;
         endcase

         // pending token goes first, then the character is scanned afresh
         if (again) begin
            emit_a = 1'b1;
            tok_a  = flush_tok;
            emit_b = idle_emit;
            tok_b  = idle_tok;
         end else if (use_idle) begin
            emit_a = idle_emit;
            tok_a  = idle_tok;
         end
         if (again || use_idle) begin
            st_in = idle_st;
            if (idle_tcnt1) tcnt_in = L'(1);
            if (idle_digit) begin
               acc_in  = M'(dig_val);
               frac_in = '0;
            end
         end
      end
   end

   assign push.push_a = fire && emit_a;
   assign push.push_b = fire && emit_b;
   assign ent_a       = {!emit_b, tok_a};
   assign ent_b       = {1'b1, tok_b};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         acc_ff  <= '0;
         frac_ff <= '0;
         tcnt_ff <= '0;
      end else if (fire) begin
         st_ff   <= st_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         tcnt_ff <= tcnt_in;
      end
   end

   // end of input always leaves the scanner idle
   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      fire && in_eoi_ff |=> st_ff == ST_IDLE)
      else $error("scanner not idle after end of input");

   // text tokens start with a nonzero count
   a_text_cnt: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_LINE || st_ff == ST_PCOM || st_ff == ST_PSTAR ||
       st_ff == ST_BRACE || st_ff == ST_STRING) |-> tcnt_ff != '0)
      else $error("text count zero inside string or comment");

   // the second slot is only used behind the first
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push_b |-> push.push_a)
      else $error("second token pushed without first");

   // flushing an idle scanner yields nothing
   a_idle_flush: assert property (@(posedge clock) disable iff (reset)
      fire && in_eoi_ff && st_ff == ST_IDLE |-> !push.push_a)
      else $error("token produced by idle flush");

endmodule

`default_nettype wire

>>> sv/pts_tokq.sv
// Result queue: small register array taking up to two tokens per cycle.
// Drives the result channel from its head entry. Depends on pts_pkg.
`default_nettype none

module pts_tokq #(
   parameter int ENT_W = 61
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  pts_pkg::tok_push_type   push,
   input  wire logic [ENT_W-1:0]   ent_a,
   input  wire logic [ENT_W-1:0]   ent_b,
   input  wire logic               pop_ready,
   output logic                    head_valid,
   output logic [ENT_W-1:0]        head_ent,
   output logic                    room
);
   import pts_pkg::*;

   localparam int PTR_W = $clog2(TQ_DEPTH);
   localparam int CNT_W = $clog2(TQ_DEPTH + 1);

   logic [ENT_W-1:0] mem_ff [TQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] wr_ptr_b;
   logic             pop;

   assign head_valid = cnt_ff != '0;
   assign head_ent   = mem_ff[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;
   // room for two more tokens regardless of this cycle's pop
   assign room       = cnt_ff <= CNT_W'(TQ_DEPTH - 2);
   assign wr_ptr_b   = PTR_W'(wr_ptr_ff + 1'b1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + CNT_W'(push.push_a) + CNT_W'(push.push_b));
      rd_ptr_in = PTR_W'(rd_ptr_ff + PTR_W'(pop));
      cnt_in    = CNT_W'(cnt_ff + CNT_W'(push.push_a) + CNT_W'(push.push_b)
                         - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push_a) mem_ff[wr_ptr_ff] <= ent_a;
      if (push.push_b) mem_ff[wr_ptr_b]  <= ent_b;
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TQ_DEPTH))
      else $error("token queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.push_a |-> cnt_ff <= CNT_W'(TQ_DEPTH - 2))
      else $error("token pushed without room");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

>>> sv/pascal_token_scanner.sv
// Top level of the Pascal token scanner: stream ports, core and result queue.
// Depends on pts_pkg, pts_core and pts_tokq.
//
//   channel  dir  tdata                                   tuser            tlast
//   req      in   [7:0] char_code                         end_of_input     -
//   rsp      out  operator_code, mantissa, fraction_digits, token_kind     last_result
//                 text_length (lowest first, zero padded)
//
// One character item is taken per cycle while the queue has room; its tokens pass through
// the input register, then the result queue, before they appear on the result channel.
// An item causing two tokens gives the result side two entries to take; the four-entry queue
// absorbs that, and the core holds its item while fewer than two entries are free.
// Reset is synchronous and active high; it empties both registers and idles the scan.
// A stalled result side fills the queue, then the input register, then drops req_tready.
`default_nettype none

module pascal_token_scanner #(
   parameter int MANTISSA_BITS = pts_pkg::MANTISSA_BITS_DEF,
   parameter int LENGTH_BITS   = pts_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] char_code
   input  wire logic                      req_tuser,   // end_of_input
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // operator_code, mantissa, fraction_digits, text_length, zero pad
   output logic [(((pts_pkg::OP_W + MANTISSA_BITS + pts_pkg::FRAC_W + LENGTH_BITS + 7)
                   >> 3) << 3) - 1:0]     rsp_tdata,
   output logic [pts_pkg::KIND_W-1:0]     rsp_tuser,   // token_kind
   output logic                           rsp_tlast    // last_result
);
   import pts_pkg::*;

   localparam int DATA_W  = OP_W + MANTISSA_BITS + FRAC_W + LENGTH_BITS;
   localparam int TDATA_W = ((DATA_W + 7) >> 3) << 3;
   localparam int ENT_W   = 1 + KIND_W + DATA_W;

   tok_push_type     push;
   logic [ENT_W-1:0] ent_a, ent_b, head_ent;
   logic             room;

   pts_core #(
      .MANTISSA_BITS (MANTISSA_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_char   (req_tdata),
      .req_eoi    (req_tuser),
      .room       (room),
      .push       (push),
      .ent_a      (ent_a),
      .ent_b      (ent_b)
   );

   pts_tokq #(
      .ENT_W (ENT_W)
   ) u_tokq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .ent_a      (ent_a),
      .ent_b      (ent_b),
      .pop_ready  (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_ent   (head_ent),
      .room       (room)
   );

   // entry layout: {last, kind, len, frac, mant, op}
   assign rsp_tlast = head_ent[ENT_W-1];
   assign rsp_tuser = head_ent[ENT_W-2 -: KIND_W];
   assign rsp_tdata = TDATA_W'(head_ent[DATA_W-1:0]);

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for pascal_token_scanner: drives source characters, predicts tokens.
// A scoreboard class holds its own scanner model and matches every result item in order.
// Depends on pts_pkg and the pascal_token_scanner RTL only.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam int MANT_W  = MANTISSA_BITS_DEF;
   localparam int LEN_W   = LENGTH_BITS_DEF;
   localparam int TDATA_W = ((OP_W + MANT_W + FRAC_W + LEN_W + 7) >> 3) << 3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_CHARS = 310;

   // token scoreboard with a character-level scanner model
   class token_board;
      typedef struct {
         logic [KIND_W-1:0] kind;
         logic [OP_W-1:0]   op;
         logic [MANT_W-1:0] mant;
         logic [FRAC_W-1:0] frac;
         logic [LEN_W-1:0]  len;
         logic              last;
      } token_type;

      token_type         tokens_due[$];
      scan_state_type    state;
      longint unsigned   digits;
      logic [FRAC_W-1:0] frac_cnt;
      int unsigned       text_cnt;
      int                errors;
      int                chars_taken;
      int                tokens_seen;
      int                kind_hits[6];

      function new();
         state = ST_IDLE;
         digits = 0;
         frac_cnt = '0;
         text_cnt = 0;
         errors = 0;
         chars_taken = 0;
         tokens_seen = 0;
         foreach (kind_hits[i]) kind_hits[i] = 0;
      endfunction

      function int pending();
         return tokens_due.size();
      endfunction

      function void push_token(tok_kind_type k, logic [OP_W-1:0] op = '0,
                               longint unsigned m = 0, logic [FRAC_W-1:0] f = '0,
                               int unsigned n = 0);
         token_type t;
         t.kind = k;
         t.op = op;
         t.mant = m[MANT_W-1:0];
         t.frac = f;
         t.len = n[LEN_W-1:0];
         t.last = 1'b0;
         tokens_due.push_back(t);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_0 && c <= CH_9;
      endfunction

      // decimal accumulate, saturating at the mantissa maximum
      function void add_digit(logic [7:0] c);
         longint unsigned d;
         longint unsigned top;
         d = 64'(c - CH_0);
         top = (64'd1 << MANT_W) - 1;
         if (digits > (top - d) / 10) digits = top;
         else digits = digits * 10 + d;
      endfunction

      function void bump_text();
         if (text_cnt < (32'd1 << LEN_W) - 1) text_cnt++;
      endfunction

      // emit whatever token is pending, return to idle
      function void flush();
         case (state)
            ST_COLON:  push_token(KIND_OP, OP_COLON);
            ST_LT:     push_token(KIND_OP, OP_LT);
            ST_GT:     push_token(KIND_OP, OP_GT);
            ST_DOT:    push_token(KIND_OP, OP_DOT);
            ST_SLASH:  push_token(KIND_OP, OP_SLASH);
            ST_LPAREN: push_token(KIND_OP, OP_LPAREN);
            ST_LINE, ST_PCOM, ST_PSTAR, ST_BRACE: push_token(KIND_COM, '0, 0, '0, text_cnt);
            ST_STRING: push_token(KIND_STR, '0, 0, '0, text_cnt);
            ST_INT:    push_token(KIND_INT, '0, digits);
            ST_INTDOT, ST_FRAC: push_token(KIND_REAL, '0, digits, frac_cnt);
            default: ;
         endcase
         state = ST_IDLE;
      endfunction

      // character seen with nothing pending
      function void scan_fresh(logic [7:0] c);
         case (c)
            CH_SPACE, CH_NL: ;
            CH_COLON:  state = ST_COLON;
            CH_LT:     state = ST_LT;
            CH_GT:     state = ST_GT;
            CH_DOT:    state = ST_DOT;
            CH_SLASH:  state = ST_SLASH;
            CH_LPAREN: state = ST_LPAREN;
            CH_LBRACE: begin
               text_cnt = 1;
               state = ST_BRACE;
            end
            CH_QUOTE: begin
               text_cnt = 1;
               state = ST_STRING;
            end
            CH_SEMI:   push_token(KIND_OP, OP_SEMI);
            CH_PLUS:   push_token(KIND_OP, OP_PLUS);
            CH_MINUS:  push_token(KIND_OP, OP_MINUS);
            CH_EQ:     push_token(KIND_OP, OP_EQ);
            CH_STAR:   push_token(KIND_OP, OP_STAR);
            CH_RPAREN: push_token(KIND_OP, OP_RPAREN);
            CH_LBRACK: push_token(KIND_OP, OP_LBRACK);
            CH_RBRACK: push_token(KIND_OP, OP_RBRACK);
            CH_AMP:    push_token(KIND_OP, OP_ELLIPSIS);
            default: begin
               if (is_digit(c)) begin
                  digits = 0;
                  frac_cnt = '0;
                  add_digit(c);
                  state = ST_INT;
               end else begin
                  push_token(KIND_ERR);
               end
            end
         endcase
      endfunction

      // accepted character: advance the model, queue the tokens it causes
      function void note_char(logic [7:0] c, logic eoi);
         int unsigned n_before;
         bit again;
         n_before = tokens_due.size();
         again = 1'b0;
         chars_taken++;
         if (eoi) begin
            flush();
         end else begin
            case (state)
               ST_IDLE: scan_fresh(c);
               ST_COLON: begin
                  if (c == CH_EQ) begin
                     push_token(KIND_OP, OP_ASSIGN);
                     state = ST_IDLE;
                  end else again = 1'b1;
               end
               ST_LT: begin
                  if (c == CH_GT) begin
                     push_token(KIND_OP, OP_NE);
                     state = ST_IDLE;
                  end else if (c == CH_EQ) begin
                     push_token(KIND_OP, OP_LE);
                     state = ST_IDLE;
                  end else again = 1'b1;
               end
               ST_GT: begin
                  if (c == CH_EQ) begin
                     push_token(KIND_OP, OP_GE);
                     state = ST_IDLE;
                  end else again = 1'b1;
               end
               ST_DOT: begin
                  if (c == CH_DOT) begin
                     push_token(KIND_OP, OP_ELLIPSIS);
                     state = ST_IDLE;
                  end else again = 1'b1;
               end
               ST_SLASH: begin
                  if (c == CH_SLASH) begin
                     text_cnt = 2;
                     state = ST_LINE;
                  end else again = 1'b1;
               end
               ST_LINE: begin
                  if (c == CH_NL) flush();
                  else bump_text();
               end
               ST_LPAREN: begin
                  if (c == CH_STAR) begin
                     text_cnt = 2;
                     state = ST_PCOM;
                  end else again = 1'b1;
               end
               ST_PCOM: begin
                  bump_text();
                  if (c == CH_STAR) state = ST_PSTAR;
               end
               ST_PSTAR: begin
                  bump_text();
                  if (c == CH_RPAREN) flush();
                  else if (c != CH_STAR) state = ST_PCOM;
               end
               ST_BRACE: begin
                  bump_text();
                  if (c == CH_RBRACE) flush();
               end
               ST_STRING: begin
                  bump_text();
                  if (c == CH_QUOTE) flush();
               end
               ST_INT: begin
                  if (is_digit(c)) add_digit(c);
                  else if (c == CH_DOT) state = ST_INTDOT;
                  else again = 1'b1;
               end
               ST_INTDOT: begin
                  // number then two points: int, then ellipsis
                  if (c == CH_DOT) begin
                     push_token(KIND_INT, '0, digits);
                     push_token(KIND_OP, OP_ELLIPSIS);
                     state = ST_IDLE;
                  end else if (is_digit(c)) begin
                     add_digit(c);
                     frac_cnt = FRAC_W'(1);
                     state = ST_FRAC;
                  end else again = 1'b1;
               end
               ST_FRAC: begin
                  if (is_digit(c)) begin
                     add_digit(c);
                     if (frac_cnt < 15) frac_cnt++;
                  end else again = 1'b1;
               end
               default: begin
                  state = ST_IDLE;
                  scan_fresh(c);
               end
            endcase
            // character ends the pending token and is scanned afresh
            if (again) begin
               flush();
               scan_fresh(c);
            end
         end
         if (tokens_due.size() > n_before) tokens_due[tokens_due.size() - 1].last = 1'b1;
      endfunction

      function void report(string field, logic [MANT_W-1:0] want, logic [MANT_W-1:0] got);
         errors++;
         $display("%0t: token %0d %s expected %0h actual %0h", $time, tokens_seen, field,
                  want, got);
      endfunction

      // compare one result item with the oldest expected token
      function void check_token(logic [KIND_W-1:0] kind, logic [OP_W-1:0] op,
                                logic [MANT_W-1:0] mant, logic [FRAC_W-1:0] frac,
                                logic [LEN_W-1:0] len, logic last);
         token_type w;
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: token with none expected, actual kind %0h op %0h mantissa %0h",
                     $time, kind, op, mant);
            return;
         end
         w = tokens_due.pop_front();
         tokens_seen++;
         if (kind < 6) kind_hits[kind]++;
         if (kind !== w.kind) report("kind", MANT_W'(w.kind), MANT_W'(kind));
         if (op !== w.op) report("operator", MANT_W'(w.op), MANT_W'(op));
         if (mant !== w.mant) report("mantissa", w.mant, mant);
         if (frac !== w.frac) report("fraction digits", MANT_W'(w.frac), MANT_W'(frac));
         if (len !== w.len) report("text length", MANT_W'(w.len), MANT_W'(len));
         if (last !== w.last) report("last flag", MANT_W'(w.last), MANT_W'(last));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata = 8'h00;
   logic               req_tuser = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]  rsp_tuser;
   logic               rsp_tlast;

   token_board board = new();
   int  sender_idle = 0;
   int  stall_pct = 0;
   bit  hold_go = 1'b0;
   int  hold_left = 0;
   int  cycles = 0;

   string op_text[20] = '{":=", ":", "<>", "<=", "<", ">=", ">", ";", ".", "..",
                          "&", "+", "-", "/", "=", "*", "(", ")", "[", "]"};

   pascal_token_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   // result side: check accepted tokens, drive ready with stalls and hold-offs
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_token(rsp_tuser, rsp_tdata[OP_W-1:0], rsp_tdata[OP_W +: MANT_W],
                           rsp_tdata[OP_W+MANT_W +: FRAC_W],
                           rsp_tdata[OP_W+MANT_W+FRAC_W +: LEN_W], rsp_tlast);
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycles, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(input logic [7:0] c, input logic eoi);
      while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tuser <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_char(c, eoi);
   endtask

   task automatic send_char(input logic [7:0] c);
      send_item(c, 1'b0);
   endtask

   // end of input carries a random, ignored byte
   task automatic send_eoi();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   function automatic logic [7:0] byte_but(logic [7:0] stop);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == stop) b = b ^ 8'h01;
      return b;
   endfunction

   task automatic send_digits(input int n);
      for (int i = 0; i < n; i++) send_char(CH_0 + 8'($urandom_range(0, 9)));
   endtask

   // mostly short numbers, now and then long enough to saturate
   function automatic int pick_count(int short_max, int long_lo, int long_hi);
      if ($urandom_range(0, 7) == 0) return $urandom_range(long_lo, long_hi);
      return $urandom_range(1, short_max);
   endfunction

   // one well-formed token with random content, or noise
   task automatic send_random_token();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         send_text(op_text[$urandom_range(0, 19)]);
      end else if (pick < 40) begin
         send_digits(pick_count(5, 10, 14));
      end else if (pick < 50) begin
         send_digits(pick_count(5, 10, 12));
         send_char(CH_DOT);
         n = pick_count(4, 14, 18);
         if ($urandom_range(0, 4) == 0) n = 0;
         send_digits(n);
      end else if (pick < 54) begin
         send_digits(pick_count(4, 10, 12));
         send_text("..");
      end else if (pick < 62) begin
         send_char(CH_QUOTE);
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) send_char(byte_but(CH_QUOTE));
         if ($urandom_range(0, 7) == 0) send_eoi();
         else send_char(CH_QUOTE);
      end else if (pick < 68) begin
         send_text("//");
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) send_char(byte_but(CH_NL));
         if ($urandom_range(0, 7) == 0) send_eoi();
         else send_char(CH_NL);
      end else if (pick < 75) begin
         // stars and close parens inside the body exercise the closing rule
         send_text("(*");
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
               0, 1:    send_char(CH_STAR);
               2:       send_char(CH_RPAREN);
               default: send_char(8'($urandom_range(0, 255)));
            endcase
         end
         if ($urandom_range(0, 7) == 0) send_eoi();
         else send_text("*)");
      end else if (pick < 81) begin
         send_char(CH_LBRACE);
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) send_char(byte_but(CH_RBRACE));
         if ($urandom_range(0, 7) == 0) send_eoi();
         else send_char(CH_RBRACE);
      end else if (pick < 90) begin
         send_char($urandom_range(0, 1) ? CH_SPACE : CH_NL);
      end else if (pick < 96) begin
         send_char(8'($urandom_range(0, 255)));
      end else begin
         send_eoi();
      end
      // adjacent tokens half the time
      if ($urandom_range(0, 1)) send_char(CH_SPACE);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_phase(input int gap_pct, input int stall_in, input bit squeeze);
      int target;
      sender_idle = gap_pct;
      stall_pct = stall_in;
      if (squeeze) hold_go = 1'b1;
      target = board.chars_taken + PHASE_CHARS;
      while (board.chars_taken < target) send_random_token();
      send_eoi();
      wait_drained();
   endtask

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every operator but >= and a lone <, saturating int, real edge cases, comment and string rules
      send_text(":=:<><=<>=>;...&+-/=*()[]");
      send_text(" 4294967296 12.x 1..(*)*){}''");
      send_char(8'h00);
      send_char(8'hFF);
      send_text("3.");
      send_eoi();
      send_eoi();
      wait_drained();

      // random phases: no idling with a long hold-off, then sender gaps, stalls, both
      run_phase(0, 0, 1'b1);
      run_phase(74, 0, 1'b0);
      run_phase(0, 74, 1'b0);
      run_phase(35, 35, 1'b0);

      // brace comment with a long body, back to back
      sender_idle = 0;
      stall_pct = 0;
      send_char(CH_LBRACE);
      repeat (40) send_char(8'h61);
      send_char(CH_RBRACE);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Scanned %0d characters into %0d tokens: %0d operators, %0d ints, %0d reals,",
               board.chars_taken, board.tokens_seen, board.kind_hits[0], board.kind_hits[1],
               board.kind_hits[2]);
      $display("%0d strings, %0d comments, %0d unknown bytes; %0d errors",
               board.kind_hits[3], board.kind_hits[4], board.kind_hits[5], board.errors);
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
sv/pts_pkg.sv
sv/pts_core.sv
sv/pts_tokq.sv
sv/pascal_token_scanner.sv
test/tb.sv
